// ----- design/dtr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types, constants and tables for the dose-to-RGBA colormap pipeline.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int DOSE_FRAC_BITS = 16;
    localparam int ISO_LEVELS     = 7;
    localparam int RONE           = 65536;
    localparam int RW             = 19;   // signed ratio, Q.16, range [-1, +2]
    localparam int NUM_W          = 32;
    localparam int DEN_W          = 32;
    localparam int QB             = 18;   // quotient bits below the saturation point
    localparam int REM_W          = 50;

    localparam logic [31:0] VIS_THR =
        32'((64'd1 << DOSE_FRAC_BITS) / 64'd1000000);

    localparam logic [1:0] MODE_SIMPLE = 2'd0;
    localparam logic [1:0] MODE_COLOR  = 2'd1;
    localparam logic [1:0] MODE_ISO    = 2'd2;
    localparam logic [1:0] MODE_HOT    = 2'd3;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_WMIN = 2'd1;
    localparam logic [1:0] REG_WMAX = 2'd2;
    localparam logic [1:0] REG_REF  = 2'd3;

    localparam int HOT_T1 = 21627;
    localparam int HOT_T2 = 43254;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] wmin;
        logic signed [31:0] wmax;
        logic [30:0]        refd;
    } t_cfg;

    typedef struct packed {
        logic shown;
        logic neg;
        logic use_div;
        logic sgn_pos;
        logic sgn_neg;
    } t_side;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_rgba;

    typedef struct packed {
        logic [31:0] level;
        t_rgba       px;
    } t_iso;

    function automatic t_iso iso_row(input logic [3:0] idx);
        t_iso row;
        case (idx)
            4'd0: row = '{32'd62259, '{8'd180, 8'd0,   8'd0,   8'd255}};
            4'd1: row = '{32'd58982, '{8'd162, 8'd0,   8'd128, 8'd255}};
            4'd2: row = '{32'd52429, '{8'd144, 8'd0,   8'd255, 8'd255}};
            4'd3: row = '{32'd45875, '{8'd126, 8'd0,   8'd255, 8'd0}};
            4'd4: row = '{32'd32768, '{8'd108, 8'd255, 8'd255, 8'd0}};
            4'd5: row = '{32'd19661, '{8'd90,  8'd255, 8'd0,   8'd0}};
            4'd6: row = '{32'd6554,  '{8'd72,  8'd255, 8'd0,   8'd128}};
            default: row = '{32'h7FFF_FFFF, '{8'd0, 8'd0, 8'd0, 8'd0}};
        endcase
        return row;
    endfunction

endpackage

// ----- design/dose_to_rgba_colormap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dose_to_rgba_colormap
// Maps a signed Q16.16 dose sample to one RGBA overlay word.
// Stages: 1 front stage, 20 divider stages, 4 color stages.
//   Throughput: one word per cycle; the whole pipeline holds while the
//   output word waits.
// Reset: synchronous, active low; clears valid bits and all config registers.
// ----------------------------------------------------------------------------
module dose_to_rgba_colormap
    import dtr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] dose_sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                          // [31:24] alpha
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg r_cfg;

    logic                  en;
    logic                  f_vld;
    t_side                 f_side;
    logic [NUM_W-1:0]      f_num;
    logic [DEN_W-1:0]      f_den;
    logic                  d_vld;
    t_side                 d_side;
    logic signed [RW-1:0]  d_ratio;
    t_rgba                 px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE: r_cfg.mode <= i_cfg_data[1:0];
                REG_WMIN: r_cfg.wmin <= $signed(i_cfg_data);
                REG_WMAX: r_cfg.wmax <= $signed(i_cfg_data);
                REG_REF:  r_cfg.refd <= i_cfg_data[30:0];
                default:  r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    dtr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_axis_tvalid),
        .i_dose  ($signed(i_s_axis_tdata)),
        .i_cfg   (r_cfg),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_num   (f_num),
        .o_den   (f_den)
    );

    dtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_ratio (d_ratio)
    );

    dtr_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_side  (d_side),
        .i_ratio (d_ratio),
        .i_mode  (r_cfg.mode),
        .o_vld   (o_m_axis_tvalid),
        .o_px    (px)
    );

    assign o_m_axis_tdata = px;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// ----- design/dtr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtr_front
// Visibility test and selection of numerator and divisor for the ratio.
// ----------------------------------------------------------------------------
module dtr_front
    import dtr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [31:0]  i_dose,
    input  t_cfg                i_cfg,
    output logic                o_vld,
    output t_side               o_side,
    output logic [NUM_W-1:0]    o_num,
    output logic [DEN_W-1:0]    o_den
);

    logic               r_vld;
    t_side              r_side;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;

    t_side              n_side;
    logic [NUM_W-1:0]   n_num;
    logic [DEN_W-1:0]   n_den;

    logic               win;
    logic signed [32:0] neg_v;
    logic signed [32:0] neg_mn;
    logic [31:0]        av;
    logic [31:0]        amn;
    logic signed [31:0] vc;
    logic signed [32:0] diff;
    logic signed [32:0] span;

    always_comb begin
        win    = i_cfg.wmax > i_cfg.wmin;
        neg_v  = -(33'(i_dose));
        neg_mn = -(33'(i_cfg.wmin));
        av     = i_dose[31] ? neg_v[31:0] : i_dose[31:0];
        amn    = i_cfg.wmin[31] ? neg_mn[31:0] : i_cfg.wmin[31:0];
        vc     = (i_dose < i_cfg.wmax) ? i_dose : i_cfg.wmax;
        diff   = 33'(vc) - 33'(i_cfg.wmin);
        span   = 33'(i_cfg.wmax) - 33'(i_cfg.wmin);

        n_side = '0;
        n_num  = av;
        n_den  = '0;
        if (win) begin
            n_side.shown = (i_dose >= i_cfg.wmin) || i_dose[31];
        end else begin
            n_side.shown = av > VIS_THR;
        end

        if (i_cfg.mode == MODE_ISO && i_cfg.refd != '0) begin
            n_side.use_div = 1'b1;
            n_side.neg     = i_dose[31];
            n_den          = {1'b0, i_cfg.refd};
        end else if (win) begin
            n_side.use_div = 1'b1;
            if (i_dose[31]) begin
                n_side.neg = 1'b1;
                n_den      = amn;
            end else begin
                n_num = diff[31:0];
                n_den = span[31:0];
            end
        end else begin
            n_side.sgn_pos = !i_dose[31] && (i_dose != '0);
            n_side.sgn_neg = i_dose[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_num  <= n_num;
            r_den  <= n_den;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule

// ----- design/dtr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtr_div
// Pipelined restoring divider, one quotient bit per stage, and ratio
// saturation to the signed Q.16 range [-1, +2].
// ----------------------------------------------------------------------------
module dtr_div
    import dtr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  t_side                  i_side,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic                   o_vld,
    output t_side                  o_side,
    output logic signed [RW-1:0]   o_ratio
);

    localparam logic signed [RW-1:0] R_LO = RW'(-RONE);
    localparam logic signed [RW-1:0] R_HI = RW'(2 * RONE);

    logic              r_vld  [0:QB];
    t_side             r_side [0:QB];
    logic [REM_W-1:0]  r_rem  [0:QB];
    logic [DEN_W-1:0]  r_den  [0:QB];
    logic [QB-1:0]     r_q    [0:QB];
    logic              r_sat  [0:QB];
    logic              r_nz   [0:QB];

    logic                  r_out_vld;
    t_side                 r_out_side;
    logic signed [RW-1:0]  r_ratio;

    logic                  n_sat;
    logic [QB-1:0]         qm;
    logic [QB-1:0]         mag;
    logic signed [RW-1:0]  n_ratio;

    assign n_sat = ({2'b0, i_num} >= {i_den, 2'b0}) && (i_num != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_rem[0]  <= REM_W'(i_num) << 16;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_sat[0]  <= n_sat;
            r_nz[0]   <= i_num != '0;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        localparam int K = QB - 1 - s;
        logic [REM_W-1:0] cmp;
        logic             ge;

        assign cmp = REM_W'(r_den[s]) << K;
        assign ge  = r_rem[s] >= cmp;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_rem[s+1]  <= ge ? (r_rem[s] - cmp) : r_rem[s];
                r_den[s+1]  <= r_den[s];
                r_q[s+1]    <= r_q[s] | (ge ? (QB'(1) << K) : '0);
                r_sat[s+1]  <= r_sat[s];
                r_nz[s+1]   <= r_nz[s];
            end
        end
    end

    always_comb begin
        if (r_sat[QB]) begin
            qm = QB'(2 * RONE);
        end else if (r_q[QB] == '0 && r_nz[QB]) begin
            qm = QB'(1);
        end else begin
            qm = r_q[QB];
        end

        if (r_side[QB].neg) begin
            mag = (qm > QB'(RONE)) ? QB'(RONE) : qm;
        end else begin
            mag = (qm > QB'(2 * RONE)) ? QB'(2 * RONE) : qm;
        end

        if (!r_side[QB].use_div) begin
            if (r_side[QB].sgn_pos) begin
                n_ratio = RW'(RONE);
            end else if (r_side[QB].sgn_neg) begin
                n_ratio = R_LO;
            end else begin
                n_ratio = '0;
            end
        end else if (r_side[QB].neg) begin
            n_ratio = -RW'(mag);
        end else begin
            n_ratio = RW'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_side <= r_side[QB];
            r_ratio    <= n_ratio;
        end
    end

    assign o_vld   = r_out_vld;
    assign o_side  = r_out_side;
    assign o_ratio = r_ratio;

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_ratio >= R_LO && r_ratio <= R_HI))
        else $error("ratio out of range");

    a_sat_zero_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_vld[QB] && r_side[QB].use_div && r_nz[QB]) |=> (r_ratio != '0))
        else $error("nonzero numerator gave zero ratio");

endmodule

// ----- design/dtr_color.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtr_color
// Ratio to RGBA: mode ramps and tables, HSV products over three stages, and
// the output register.
// ----------------------------------------------------------------------------
module dtr_color
    import dtr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  t_side                 i_side,
    input  logic signed [RW-1:0]  i_ratio,
    input  logic [1:0]            i_mode,
    output logic                  o_vld,
    output t_rgba                 o_px
);

    localparam logic [18:0] H_MAX = 19'(6 * RONE);
    localparam logic [16:0] ONE17 = 17'(RONE);

    function automatic logic [7:0] to8(input logic [16:0] x);
        logic [25:0] m;
        m = 26'(x) * 26'd255 + 26'd32768;
        return m[23:16];
    endfunction

    // stage 1
    logic        r1_vld;
    logic        r1_shown;
    logic [1:0]  r1_mode;
    t_rgba       r1_other;
    logic [18:0] r1_h6;
    logic [16:0] r1_s;
    logic [16:0] r1_v;
    logic [7:0]  r1_al;
    logic        r1_zero;

    logic                  isneg;
    logic signed [RW-1:0]  negr;
    logic [16:0]           a17;
    logic [16:0]           d17;
    logic [16:0]           aa;
    logic [31:0]           rnu;
    logic [31:0]           r5;
    logic [31:0]           m_s;
    logic [31:0]           m_1;
    logic [31:0]           m_2;
    logic [31:0]           hr;
    logic signed [20:0]    hg;
    logic signed [20:0]    hb;
    logic [16:0]           cg;
    logic [16:0]           cb;
    logic [31:0]           tt;
    logic [31:0]           x;
    logic [47:0]           px48;
    logic [31:0]           y;
    t_rgba                 n_other;
    t_rgba                 iso_px;
    t_iso                  iso_sel;
    logic [18:0]           n_h6;
    logic [16:0]           n_s;
    logic [16:0]           n_v;
    logic [7:0]            n_al;

    always_comb begin
        isneg = i_ratio[RW-1];
        negr  = -i_ratio;
        a17   = isneg ? ((negr > RW'(RONE)) ? ONE17 : negr[16:0]) : '0;
        d17   = isneg ? '0 : ((i_ratio > RW'(RONE)) ? ONE17 : i_ratio[16:0]);
        aa    = isneg ? a17 : d17;
        rnu   = isneg ? '0 : 32'(i_ratio[RW-2:0]);
        r5    = rnu * 32'd5;

        n_other = '0;
        iso_px  = '0;
        iso_sel = '0;
        m_s     = '0;
        m_1     = '0;
        m_2     = '0;
        hr      = '0;
        hg      = '0;
        hb      = '0;
        cg      = '0;
        cb      = '0;
        case (i_mode)
            MODE_SIMPLE: begin
                m_s = (32'd255 * 32'(aa)) >> 16;
                n_other.r = isneg ? 8'd0 : 8'd255;
                n_other.b = isneg ? 8'd255 : 8'd0;
                n_other.a = (m_s < 32'd40) ? 8'd40 : m_s[7:0];
            end
            MODE_ISO: begin
                if (isneg) begin
                    m_1 = (32'd155 * 32'(a17)) >> 16;
                    m_2 = (32'd135 * 32'(a17)) >> 16;
                    n_other.r = 8'd50;
                    n_other.g = 8'd50;
                    n_other.b = 8'd100 + m_1[7:0];
                    n_other.a = m_2[7:0];
                end else if (i_ratio != '0) begin
                    for (int k = ISO_LEVELS - 1; k >= 0; k--) begin
                        iso_sel = iso_row(4'(k));
                        if (rnu >= iso_sel.level) begin
                            iso_px = iso_sel.px;
                        end
                    end
                    n_other = iso_px;
                end
            end
            MODE_HOT: begin
                if (isneg) begin
                    m_1 = (32'd200 * 32'(a17)) >> 16;
                    m_2 = (32'd204 * 32'(a17)) >> 16;
                    n_other.b = m_1[7:0];
                    n_other.a = m_2[7:0];
                end else begin
                    hr = 32'd3 * 32'(d17);
                    hr = (hr > 32'(RONE)) ? 32'(RONE) : hr;
                    hg = 21'sd3 * ($signed({4'b0, d17}) - 21'sd21627);
                    hb = 21'sd3 * ($signed({4'b0, d17}) - 21'sd43254);
                    cg = (hg < 0) ? '0 : ((hg > 21'sd65536) ? ONE17 : hg[16:0]);
                    cb = (hb < 0) ? '0 : ((hb > 21'sd65536) ? ONE17 : hb[16:0]);
                    m_s = (32'd255 * hr) >> 16;
                    m_1 = (32'd255 * 32'(cg)) >> 16;
                    m_2 = (32'd255 * 32'(cb)) >> 16;
                    n_other.r = m_s[7:0];
                    n_other.g = m_1[7:0];
                    n_other.b = m_2[7:0];
                    n_other.a = 8'd204;
                end
            end
            default: n_other = '0;
        endcase

        n_s  = ONE17;
        n_v  = ONE17;
        tt   = '0;
        x    = '0;
        px48 = '0;
        y    = '0;
        if (isneg) begin
            n_h6 = 19'(32'd294912 - (32'(a17) >> 1));
            x    = 32'(7 * RONE) + 32'd3 * 32'(a17);
            px48 = 48'(x) * 48'd838861;
            n_s  = px48[39:23];
            n_v  = 17'((32'(RONE) + 32'(a17)) >> 1);
            y    = (32'd204 * (32'd131072 + 32'd3 * 32'(a17))) >> 16;
            px48 = 48'(y) * 48'd52429;
            n_al = px48[25:18];
        end else begin
            if (rnu > 32'(RONE)) begin
                tt   = 32'd2 * (rnu - 32'(RONE));
                tt   = (tt > 32'(RONE)) ? 32'(RONE) : tt;
                n_h6 = 19'(32'(6 * RONE) - tt);
                px48 = 48'(tt + 32'd4) * 48'd52429;
                n_v  = 17'(32'(RONE) - 32'(px48[35:18]));
            end else if (r5 <= 32'(RONE)) begin
                n_h6 = 19'(32'(4 * RONE) - r5);
                n_s  = 17'(32'd52428 + rnu);
            end else if (r5 <= 32'(2 * RONE)) begin
                n_h6 = 19'(32'(3 * RONE) - (r5 - 32'(RONE)));
            end else if (r5 <= 32'(3 * RONE)) begin
                n_h6 = 19'(32'(2 * RONE) - (r5 - 32'(2 * RONE)));
            end else if (r5 <= 32'(4 * RONE)) begin
                n_h6 = 19'(32'(RONE) - ((r5 - 32'(3 * RONE)) >> 1));
            end else begin
                n_h6 = 19'(32'(RONE / 2) - ((r5 - 32'(4 * RONE)) >> 1));
            end
            if (rnu <= 32'd6553) begin
                y    = (32'd204 * (32'd196608 + 32'd70 * rnu)) >> 16;
                px48 = 48'(y) * 48'd52429;
                n_al = px48[26:19];
            end else if (rnu >= 32'd58983) begin
                n_al = 8'd244;
            end else begin
                n_al = 8'd204;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_shown <= i_side.shown;
            r1_mode  <= i_mode;
            r1_other <= n_other;
            r1_h6    <= n_h6;
            r1_s     <= n_s;
            r1_v     <= n_v;
            r1_al    <= n_al;
            r1_zero  <= i_ratio == '0;
        end
    end

    // stage 2
    logic        r2_vld;
    logic        r2_shown;
    logic [1:0]  r2_mode;
    t_rgba       r2_other;
    logic [7:0]  r2_al;
    logic        r2_zero;
    logic [2:0]  r2_i;
    logic [16:0] r2_v;
    logic [16:0] r2_p;
    logic [16:0] r2_sf;
    logic [16:0] r2_smf;

    logic [18:0] hc;
    logic [16:0] fr;
    logic [33:0] pp;
    logic [33:0] psf;
    logic [33:0] psmf;

    always_comb begin
        hc = (r1_h6 > H_MAX) ? H_MAX : r1_h6;
        if (hc >= H_MAX) begin
            hc = hc - H_MAX;
        end
        fr   = {1'b0, hc[15:0]};
        pp   = 34'(r1_v) * 34'(ONE17 - r1_s);
        psf  = 34'(r1_s) * 34'(fr);
        psmf = 34'(r1_s) * 34'(ONE17 - fr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_shown <= r1_shown;
            r2_mode  <= r1_mode;
            r2_other <= r1_other;
            r2_al    <= r1_al;
            r2_zero  <= r1_zero;
            r2_i     <= hc[18:16];
            r2_v     <= r1_v;
            r2_p     <= pp[32:16];
            r2_sf    <= psf[32:16];
            r2_smf   <= psmf[32:16];
        end
    end

    // stage 3
    logic        r3_vld;
    logic        r3_shown;
    logic [1:0]  r3_mode;
    t_rgba       r3_other;
    logic [7:0]  r3_al;
    logic        r3_zero;
    logic [2:0]  r3_i;
    logic [16:0] r3_v;
    logic [16:0] r3_p;
    logic [16:0] r3_q;
    logic [16:0] r3_t;

    logic [33:0] pq;
    logic [33:0] pt;

    assign pq = 34'(r2_v) * 34'(ONE17 - r2_sf);
    assign pt = 34'(r2_v) * 34'(ONE17 - r2_smf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_shown <= r2_shown;
            r3_mode  <= r2_mode;
            r3_other <= r2_other;
            r3_al    <= r2_al;
            r3_zero  <= r2_zero;
            r3_i     <= r2_i;
            r3_v     <= r2_v;
            r3_p     <= r2_p;
            r3_q     <= pq[32:16];
            r3_t     <= pt[32:16];
        end
    end

    // stage 4: output register
    logic   r4_vld;
    t_rgba  r4_px;

    logic [16:0] c0;
    logic [16:0] c1;
    logic [16:0] c2;
    t_rgba       n_px;

    always_comb begin
        case (r3_i)
            3'd0:    begin c0 = r3_v; c1 = r3_t; c2 = r3_p; end
            3'd1:    begin c0 = r3_q; c1 = r3_v; c2 = r3_p; end
            3'd2:    begin c0 = r3_p; c1 = r3_v; c2 = r3_t; end
            3'd3:    begin c0 = r3_p; c1 = r3_q; c2 = r3_v; end
            3'd4:    begin c0 = r3_t; c1 = r3_p; c2 = r3_v; end
            default: begin c0 = r3_v; c1 = r3_p; c2 = r3_q; end
        endcase

        if (!r3_shown) begin
            n_px = '0;
        end else if (r3_mode == MODE_COLOR) begin
            if (r3_zero) begin
                n_px = '0;
            end else begin
                n_px = '{r3_al, to8(c2), to8(c1), to8(c0)};
            end
        end else begin
            n_px = r3_other;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_px <= n_px;
        end
    end

    assign o_vld = r4_vld;
    assign o_px  = r4_px;

    a_hidden_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r3_vld && !r3_shown) |=> (r4_px == '0))
        else $error("hidden pixel not transparent");

endmodule
